// File: hw/rtl/lcbn_pkg.sv
// shared types and constants of the load-cell bias and noise calibrator
// no dependencies
package lcbn_pkg;

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WSHIFT = 32 - WEIGHT_FRAC_BITS;
  localparam int FLOOR_SH = 2 * WEIGHT_FRAC_BITS - 32;
  localparam int FLOOR_L = (FLOOR_SH > 0) ? FLOOR_SH : 0;
  localparam int FLOOR_R = (FLOOR_SH < 0) ? -FLOOR_SH : 0;

  localparam logic [31:0] KG_RESET = 32'd400000;
  localparam logic [15:0] SAMPLES_RESET = 16'd1000;
  localparam logic [31:0] FLOOR_RESET = 32'd300648;

  localparam logic [1:0] REG_KG = 2'd0;
  localparam logic [1:0] REG_SAMPLES = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;

  localparam logic [6:0] STEPS_MEAN = 7'd33;
  localparam logic [6:0] STEPS_VAR = 7'd64;
  localparam logic [6:0] STEPS_ROOT = 7'd32;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
    logic [6:0] steps;
  } iter_req_t;

  typedef struct packed {
    logic [31:0] kg_per_lsb;
    logic [15:0] calib_samples;
    logic [31:0] variance_floor;
  } cfg_t;

  function automatic logic [63:0] floor_scale(input logic [31:0] v);
    return (64'(v) << FLOOR_L) >> FLOOR_R;
  endfunction

endpackage

// File: hw/rtl/lcbn_cfg.sv
// apb register file: conversion factor, run length, variance floor
// depends on lcbn_pkg
module lcbn_cfg import lcbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kg_per_lsb <= KG_RESET;
      cfg.calib_samples <= SAMPLES_RESET;
      cfg.variance_floor <= FLOOR_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_KG:      cfg.kg_per_lsb <= pwdata;
        REG_SAMPLES: cfg.calib_samples <= pwdata[15:0];
        REG_FLOOR:   cfg.variance_floor <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KG:      prdata = cfg.kg_per_lsb;
      REG_SAMPLES: prdata = {16'd0, cfg.calib_samples};
      REG_FLOOR:   prdata = cfg.variance_floor;
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// File: hw/rtl/lcbn_iter.sv
// shared shift-compare-subtract unit: restoring divide or bitwise square root
// depends on lcbn_pkg
module lcbn_iter import lcbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  iter_req_t   req,
  input  logic [63:0] operand,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [63:0] result
);

  iter_mode_t  mode;
  logic [63:0] acc;
  logic [35:0] rem;
  logic [15:0] dvs;
  logic [6:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    if (mode == MODE_SQRT) begin
      rem_sh = {rem[33:0], acc[63:62]};
      trial = {1'b0, result[32:0], 2'b01};
    end else begin
      rem_sh = {rem[34:0], acc[63]};
      trial = {20'd0, dvs};
    end
    ge = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 7'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= req.steps;
      mode <= req.mode;
      acc <= operand;
      dvs <= divisor;
      rem <= 36'd0;
      result <= 64'd0;
    end else if (busy) begin
      acc <= (mode == MODE_SQRT) ? {acc[61:0], 2'b00} : {acc[62:0], 1'b0};
      rem <= ge ? diff : rem_sh;
      result <= {result[62:0], ge};
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/load_cell_bias_noise_calibrator.sv
// top level: weight scaling, bias and noise correction, welford calibration sequencer
// depends on lcbn_pkg, lcbn_cfg, lcbn_iter
//
//  channel  | direction | payload
//  s_*      | in        | tdata raw_sample, tuser operation/data_ready
//  m_*      | out       | tdata corrected_weight/noise_std_dev, tuser flags
//  apb      | in/out    | kg_per_lsb, calib_samples, variance_floor
//
// a plain item goes through S_WMUL, S_WEIGHT, S_CORR and S_OUT; an item of a calibration run
// also waits for the 33-step mean division in the shared divide/root unit
// the item that ends a run adds the 64-step variance division and 32-step root
// rst is synchronous; s_tready is high only in the idle state
// a result waiting in the output register does not block the next request
module load_cell_bias_noise_calibrator import lcbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // raw_sample
  input  logic [1:0]  s_tuser,   // operation, data_ready
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // corrected_weight, noise_std_dev
  output logic [1:0]  m_tuser,   // calibrating, calibration_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_WMUL, S_WEIGHT, S_CORR, S_DIV, S_REST, S_ACC, S_VDIV, S_VAR,
    S_SQRT, S_OUT
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic               op;
  logic signed [23:0] raw;
  logic               rdy;
  logic signed [31:0] held;
  logic signed [31:0] mean;
  logic [63:0]        sumsq;
  logic [15:0]        count;
  logic               active;
  logic signed [31:0] zp;
  logic [31:0]        std;
  logic signed [31:0] corr;
  logic               done;
  logic               dneg;
  logic [32:0]        dmag;
  logic signed [67:0] prod;

  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] wsh;
  logic signed [31:0] wsat;
  logic signed [35:0] cdiff;
  logic signed [31:0] csat;
  logic [15:0]        cnt_inc;
  logic [15:0]        cnt_new;
  logic signed [31:0] mean_base;
  logic signed [32:0] delta;
  logic signed [32:0] rest;
  logic [32:0]        rmag;
  logic [33:0]        qsigned;
  logic [63:0]        term;
  logic [64:0]        sum_ext;
  logic [63:0]        sum_new;
  logic [15:0]        target;
  logic [63:0]        fl;
  logic [63:0]        var_fl;

  iter_req_t   ireq;
  logic [63:0] iop;
  logic [15:0] idvs;
  logic        ibusy;
  logic [63:0] ires;

  lcbn_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  lcbn_iter u_iter (
    .clk(clk), .rst(rst), .req(ireq), .operand(iop), .divisor(idvs),
    .busy(ibusy), .result(ires)
  );

  assign s_tready = (state == S_IDLE);

  always_comb begin
    if (state == S_REST) begin
      ma = {1'b0, dmag};
      mb = {1'b0, rmag};
    end else begin
      ma = 34'(raw);
      mb = {2'b00, cfg.kg_per_lsb};
    end

    wsh = prod >>> WSHIFT;
    if (wsh > 68'sd2147483647) wsat = 32'sh7fffffff;
    else if (wsh < -68'sd2147483648) wsat = 32'sh80000000;
    else wsat = wsh[31:0];

    cdiff = 36'(held) - (36'(zp) + 36'(signed'({1'b0, std})) * 36'sd3);
    if (cdiff > 36'sd2147483647) csat = 32'sh7fffffff;
    else if (cdiff < -36'sd2147483648) csat = 32'sh80000000;
    else csat = cdiff[31:0];

    cnt_inc = (op ? 16'd0 : count) + 16'd1;
    cnt_new = (cnt_inc == 16'd0) ? 16'd1 : cnt_inc;
    mean_base = op ? 32'sd0 : mean;
    delta = 33'(held) - 33'(mean_base);

    qsigned = dneg ? (34'd0 - {1'b0, ires[32:0]}) : {1'b0, ires[32:0]};
    rest = 33'(held) - 33'(mean);
    rmag = rest[32] ? (33'd0 - rest) : rest;

    term = (prod[67:64] != 4'd0) ? 64'hffff_ffff_ffff_ffff : prod[63:0];
    sum_ext = {1'b0, sumsq} + {1'b0, term};
    sum_new = sum_ext[64] ? 64'hffff_ffff_ffff_ffff : sum_ext[63:0];
    target = (cfg.calib_samples < 16'd2) ? 16'd2 : cfg.calib_samples;

    fl = floor_scale(cfg.variance_floor);
    var_fl = (ires < fl) ? fl : ires;

    ireq = '{start: 1'b0, mode: MODE_DIV, steps: STEPS_MEAN};
    iop = {dmag, 31'd0};
    idvs = count;
    unique case (state)
      S_CORR: begin
        ireq.start = op || active;
        iop = {(delta[32] ? (33'd0 - delta) : delta), 31'd0};
        idvs = cnt_new;
      end
      S_ACC: begin
        ireq.start = (count >= target);
        ireq.steps = STEPS_VAR;
        iop = sum_new;
        idvs = count - 16'd1;
      end
      S_VAR: begin
        ireq.start = 1'b1;
        ireq.mode = MODE_SQRT;
        ireq.steps = STEPS_ROOT;
        iop = var_fl;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      held <= 32'sd0;
      mean <= 32'sd0;
      sumsq <= 64'd0;
      count <= 16'd0;
      active <= 1'b0;
      zp <= 32'sd0;
      std <= 32'd0;
      done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      prod <= ma * mb;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            raw <= s_tdata;
            op <= s_tuser[0];
            rdy <= s_tuser[1];
            done <= 1'b0;
            state <= S_WMUL;
          end
        end
        S_WMUL: state <= S_WEIGHT;
        S_WEIGHT: begin
          if (rdy) held <= wsat;
          state <= S_CORR;
        end
        S_CORR: begin
          corr <= csat;
          if (op || active) begin
            active <= 1'b1;
            if (op) sumsq <= 64'd0;
            mean <= mean_base;
            count <= cnt_new;
            dneg <= delta[32];
            dmag <= delta[32] ? (33'd0 - delta) : delta;
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (!ibusy) begin
            mean <= 32'(34'(mean) + qsigned);
            state <= S_REST;
          end
        end
        S_REST: state <= S_ACC;
        S_ACC: begin
          sumsq <= sum_new;
          state <= (count >= target) ? S_VDIV : S_OUT;
        end
        S_VDIV: begin
          if (!ibusy) state <= S_VAR;
        end
        S_VAR: state <= S_SQRT;
        S_SQRT: begin
          if (!ibusy) begin
            std <= ires[31:0];
            zp <= mean;
            active <= 1'b0;
            done <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {std, corr};
            m_tuser <= {done, active};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: verif/load_cell_bias_noise_calibrator_tb.sv
// testbench for load_cell_bias_noise_calibrator: random and directed sample streams,
// apb register settings and a self-contained welford predictor checked against every result
// depends on lcbn_pkg and the load_cell_bias_noise_calibrator rtl
module load_cell_bias_noise_calibrator_tb import lcbn_pkg::*; ();

  typedef struct {
    logic               op;
    logic signed [23:0] raw;
    logic               dr;
  } sample_t;

  typedef struct {
    logic [31:0] weight;
    logic        calibrating;
    logic        done;
    logic [31:0] std;
  } reading_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  load_cell_bias_noise_calibrator dut (.*);

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       mismatches = 0;
  int       send_idle_pct = 0, recv_stall_pct = 0;

  // predictor state
  longint unsigned kg, samples_cfg, floor_cfg;
  longint          held_w, mean_w, zero_pt;
  longint unsigned sum_sq, cnt, dev;
  bit              active;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic predict_reading(input sample_t s);
    longint prod, corr, delta, rest;
    longint unsigned a, b, tgt, fl, var_w;
    logic [127:0] term, total;
    reading_t r;
    bit done = 0;
    if (s.dr) begin
      prod = longint'(s.raw) * longint'(kg);
      held_w = sat32(prod >>> WSHIFT);
    end
    corr = sat32(held_w - (zero_pt + 3 * longint'(dev)));
    if (s.op) begin
      active = 1;
      mean_w = 0;
      sum_sq = 0;
      cnt = 0;
    end
    if (active) begin
      cnt = (cnt + 1) & 64'hFFFF;
      if (cnt == 0) cnt = 1;
      delta = held_w - mean_w;
      mean_w += delta / longint'(cnt);
      rest = held_w - mean_w;
      a = delta < 0 ? -delta : delta;
      b = rest < 0 ? -rest : rest;
      term = 128'(a) * 128'(b);
      if (term > 128'(64'hFFFF_FFFF_FFFF_FFFF)) term = 128'(64'hFFFF_FFFF_FFFF_FFFF);
      total = 128'(sum_sq) + term;
      sum_sq = (total > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                          : total[63:0];
      tgt = samples_cfg < 2 ? 2 : samples_cfg;
      if (cnt >= tgt) begin
        var_w = sum_sq / (cnt - 1);
        fl = (floor_cfg << FLOOR_L) >> FLOOR_R;
        if (var_w < fl) var_w = fl;
        zero_pt = mean_w;
        dev = isqrt(var_w) & 64'hFFFF_FFFF;
        active = 0;
        done = 1;
      end
    end
    r.weight = corr[31:0];
    r.calibrating = active;
    r.done = done;
    r.std = dev[31:0];
    expected_readings.push_back(r);
  endtask

  // sample driver
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_reading('{s_tuser[0], s_tdata, s_tuser[1]});
        nv = 0;
      end
      if (!nv && pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= pending_samples[0].raw;
        s_tuser <= {pending_samples[0].dr, pending_samples[0].op};
        void'(pending_samples.pop_front());
        nv = 1;
      end
      s_tvalid <= nv;
    end
  end

  // result monitor
  always @(posedge clk) begin
    reading_t e;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %b", m_tdata, m_tuser);
        end else begin
          e = expected_readings.pop_front();
          if (m_tdata[31:0] !== e.weight || m_tdata[63:32] !== e.std ||
              m_tuser[0] !== e.calibrating || m_tuser[1] !== e.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected w=%h std=%h cal=%b done=%b, got w=%h std=%h tuser=%b",
                       e.weight, e.std, e.calibrating, e.done,
                       m_tdata[31:0], m_tdata[63:32], m_tuser);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_KG:      kg = 64'(val);
      REG_SAMPLES: samples_cfg = 64'(val[15:0]);
      REG_FLOOR:   floor_cfg = 64'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || s_tvalid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic push_sample(input bit op, input logic [23:0] raw, input bit dr);
    sample_t s;
    s.op = op; s.raw = raw; s.dr = dr;
    pending_samples.push_back(s);
  endtask

  initial begin
    logic [31:0] kg_sel, fl_sel;
    logic [15:0] n_sel;
    logic [23:0] base, noise_v;
    rst = 1;
    s_tdata = 0; s_tuser = 0; s_tvalid = 0; m_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    kg = KG_RESET; samples_cfg = SAMPLES_RESET; floor_cfg = FLOOR_RESET;
    held_w = 0; mean_w = 0; zero_pt = 0; sum_sq = 0; cnt = 0; dev = 0; active = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: extremes, held weight, short runs, restart
    write_reg(REG_SAMPLES, 32'd3);
    write_reg(REG_FLOOR, 32'd0);
    push_sample(0, 24'h7FFFFF, 1);
    push_sample(0, 24'h800000, 1);
    push_sample(0, 24'h000000, 1);
    push_sample(0, 24'hFFFFFF, 1);
    push_sample(0, 24'h123456, 0);
    push_sample(1, 24'h001000, 1);
    push_sample(0, 24'h001100, 1);
    push_sample(0, 24'h000F00, 1);
    push_sample(0, 24'h7FFFFF, 0);
    push_sample(1, 24'h7FFFFF, 1);
    push_sample(1, 24'h800000, 1);
    push_sample(0, 24'h7FFFFF, 1);
    push_sample(0, 24'h800000, 1);
    push_sample(0, 24'h000010, 1);
    push_sample(1, 24'h000020, 0);
    push_sample(0, 24'h000020, 0);
    push_sample(0, 24'h000020, 0);
    push_sample(0, 24'h800000, 1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      case ($urandom_range(4))
        0: kg_sel = 32'd0;
        1: kg_sel = 32'hFFFF_FFFF;
        2: kg_sel = KG_RESET;
        3: kg_sel = $urandom_range(1 << 20);
        default: kg_sel = $urandom;
      endcase
      case ($urandom_range(3))
        0: fl_sel = 32'd0;
        1: fl_sel = 32'hFFFF_FFFF;
        2: fl_sel = FLOOR_RESET;
        default: fl_sel = $urandom;
      endcase
      if (ph == 5) n_sel = 16'hFFFF;
      else if (ph == 2) n_sel = 16'd0;
      else if (ph == 3) n_sel = 16'd1;
      else if (ph == 9) n_sel = 16'd40;
      else n_sel = 16'($urandom_range(2, 10));
      write_reg(REG_KG, kg_sel);
      write_reg(REG_SAMPLES, 32'(n_sel));
      write_reg(REG_FLOOR, fl_sel);
      base = 24'($urandom);
      for (int i = 0; i < 125; i++) begin
        noise_v = base + 24'($urandom_range(64)) - 24'd32;
        if ($urandom_range(7) == 0) noise_v = 24'($urandom);
        push_sample($urandom_range(9) == 0 || i == 0, noise_v, $urandom_range(5) != 0);
      end
      // lower the run length while a run is in flight
      if (ph == 9) begin
        while (pending_samples.size() > 60) @(posedge clk);
        drain();
        if (active) write_reg(REG_SAMPLES, 32'd2);
        push_sample(0, base, 1);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS load_cell_bias_noise_calibrator");
    end else begin
      $display("FAIL load_cell_bias_noise_calibrator");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL load_cell_bias_noise_calibrator");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lcbn_pkg.sv
hw/rtl/lcbn_cfg.sv
hw/rtl/lcbn_iter.sv
hw/rtl/load_cell_bias_noise_calibrator.sv
verif/load_cell_bias_noise_calibrator_tb.sv
